>>> rtl/assert_macros.svh
// Assertion macros used by the checker of the button press classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is low.
`define BPC_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Checked at every rising edge, reset cycles included.
`define BPC_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> rtl/bpc_pkg.sv
// Shared types and constants of the button press classifier.
package bpc_pkg;

  // Width of each configuration register.
  localparam int CFG_W = 16;

  // Width of the configuration bus address and data.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_LONG_PRESS    = 1'b0;
  localparam logic REG_DOUBLE_WINDOW = 1'b1;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET    = 16'd50;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RESET = 16'd10;

  // Event codes reported per tick.
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } bpc_event_t;

  // Configuration as seen by the classifier.
  typedef struct packed {
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] double_window_ticks;
  } bpc_cfg_t;

endpackage

>>> rtl/bpc_scan_if.sv
// Stream interfaces for scan ticks and classification reports.
interface bpc_scan_if;
  logic valid;
  logic ready;
  logic key_released;

  modport source (output valid, output key_released, input ready);
  modport sink (input valid, input key_released, output ready);
endinterface

interface bpc_report_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;
  logic       idle;

  modport source (output valid, output press_event, output idle, input ready);
  modport sink (input valid, input press_event, input idle, output ready);
endinterface

>>> rtl/bpc_cfg_regs.sv
// APB configuration registers of the button press classifier.
module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output bpc_cfg_t          cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks    <= LONG_PRESS_RESET;
      cfg.double_window_ticks <= DOUBLE_WINDOW_RESET;
    end else if (wr_en) begin
      if (reg_sel == REG_LONG_PRESS) begin
        cfg.long_press_ticks <= pwdata[CFG_W-1:0];
      end else begin
        cfg.double_window_ticks <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Read data is a plain decode of the address.
  always_comb begin
    if (reg_sel == REG_LONG_PRESS) begin
      prdata = DATA_W'(cfg.long_press_ticks);
    end else begin
      prdata = DATA_W'(cfg.double_window_ticks);
    end
  end

endmodule

>>> rtl/bpc_classifier.sv
// Press classification state machine with hold and gap counters.
module bpc_classifier
  import bpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       key_released,
  input  bpc_cfg_t   cfg,
  output bpc_event_t press_event,
  output logic       idle
);

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_HELD      = 5'b00010,
    PH_LONG_WAIT = 5'b00100,
    PH_GAP       = 5'b01000,
    PH_SECOND    = 5'b10000
  } phase_t;

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] hold_count;
  logic [COUNT_BITS-1:0] hold_count_next;
  logic [COUNT_BITS-1:0] gap_count;
  logic [COUNT_BITS-1:0] gap_count_next;
  logic [COUNT_BITS-1:0] hold_inc;
  logic [COUNT_BITS-1:0] gap_inc;
  logic                  hold_over;
  logic                  gap_under;
  logic                  gap_over;

  // Saturating increments and threshold compares.
  assign hold_inc  = (&hold_count) ? hold_count : hold_count + 1'b1;
  assign gap_inc   = (&gap_count) ? gap_count : gap_count + 1'b1;
  assign hold_over = CMP_W'(hold_inc) > CMP_W'(cfg.long_press_ticks);
  assign gap_under = CMP_W'(gap_inc) < CMP_W'(cfg.double_window_ticks);
  assign gap_over  = CMP_W'(gap_inc) > CMP_W'(cfg.double_window_ticks);

  // Next state and event for the current tick.
  always_comb begin
    phase_next      = phase;
    hold_count_next = hold_count;
    gap_count_next  = gap_count;
    press_event     = EV_NONE;
    case (phase)
      PH_IDLE: begin
        if (!key_released) begin
          phase_next      = PH_HELD;
          hold_count_next = '0;
        end
      end
      PH_HELD: begin
        if (key_released) begin
          phase_next     = PH_GAP;
          gap_count_next = '0;
        end else begin
          hold_count_next = hold_inc;
          if (hold_over) begin
            press_event = EV_LONG;
            phase_next  = PH_LONG_WAIT;
          end
        end
      end
      PH_LONG_WAIT: begin
        if (key_released) begin
          phase_next = PH_IDLE;
        end
      end
      PH_GAP: begin
        gap_count_next = gap_inc;
        if (!key_released) begin
          // A press at or after the window is swallowed.
          if (gap_under) begin
            phase_next      = PH_SECOND;
            hold_count_next = '0;
          end
        end else if (gap_over) begin
          press_event = EV_SHORT;
          phase_next  = PH_IDLE;
        end
      end
      PH_SECOND: begin
        if (key_released) begin
          press_event = EV_DOUBLE;
          phase_next  = PH_IDLE;
        end else begin
          hold_count_next = hold_inc;
          if (hold_over) begin
            press_event = EV_LONG;
            phase_next  = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  assign idle = (phase_next == PH_IDLE);

  // State advances once per classified tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hold_count <= '0;
      gap_count  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      hold_count <= hold_count_next;
      gap_count  <= gap_count_next;
    end
  end

endmodule

>>> rtl/button_press_classifier_unit.sv
// Top level of the button press classifier.
//
//   channel  | direction | payload                | handshake
//   ---------+-----------+------------------------+----------------------------
//   scan     | in        | key_released           | valid/ready
//   report   | out       | press_event, idle      | valid/ready
//   apb      | in        | long, window registers | psel/penable, pready high
//
// One scan tick is taken every clock while reports are not stalled; each tick yields one report.
// The input register and the result register each hold one transaction, and the
// state machine steps as a transaction moves from the first to the second.
// Reset clears the state, both valid flags and the registers to 50 and 10 ticks.
// A stalled report holds its data and stalls the input only once both registers are full.
module button_press_classifier_unit
  import bpc_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  bpc_scan_if.sink          scan,
  bpc_report_if.source      report,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  bpc_cfg_t   cfg;
  logic       in_valid;
  logic       in_key;
  logic       out_valid;
  logic [1:0] out_event;
  logic       out_idle;
  logic       step;
  bpc_event_t step_event;
  logic       step_idle;

  bpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_classifier #(
    .COUNT_BITS (COUNT_BITS)
  ) u_class (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .key_released (in_key),
    .cfg          (cfg),
    .press_event  (step_event),
    .idle         (step_idle)
  );

  // A tick is classified when the result register is free or draining.
  assign step       = in_valid && (!out_valid || report.ready);
  assign scan.ready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan.valid && scan.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_key <= scan.key_released;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event <= step_event;
      out_idle  <= step_idle;
    end
  end

  assign report.valid       = out_valid;
  assign report.press_event = out_event;
  assign report.idle        = out_idle;

endmodule

>>> rtl/bpc_checker.sv
// Port-level assertions for the button press classifier, bound to the top level.
`include "assert_macros.svh"

module bpc_checker
  import bpc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       scan_valid,
  input logic       scan_ready,
  input logic       report_valid,
  input logic       report_ready,
  input logic [1:0] report_event,
  input logic       report_idle,
  input logic       pready
);

  // Nothing is reported in the cycle after reset.
  `BPC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !report_valid, "report valid after reset")

  // A stalled report keeps its data.
  `BPC_ASSERT(a_stall_hold, clk, rst, report_valid && !report_ready |=> report_valid && $stable(report_event) && $stable(report_idle), "stalled report changed")

  // Short and double clicks always end in idle.
  `BPC_ASSERT(a_click_idle, clk, rst, report_valid && (report_event == EV_SHORT || report_event == EV_DOUBLE) |-> report_idle, "click report not idle")

  // An empty pipeline never refuses a tick.
  `BPC_ASSERT(a_ready_empty, clk, rst, $past(!report_valid) && !report_valid |-> scan_ready, "input stalled while empty")

  // The configuration port never waits.
  `BPC_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready low")

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
  .clk          (clk),
  .rst          (rst),
  .scan_valid   (scan.valid),
  .scan_ready   (scan.ready),
  .report_valid (report.valid),
  .report_ready (report.ready),
  .report_event (report.press_event),
  .report_idle  (report.idle),
  .pready       (pready)
);

>>> test/tb_button_press_classifier_unit.sv
// Self-checking testbench for the button press classifier unit.
`timescale 1ns / 1ps

module tb_button_press_classifier_unit
  import bpc_pkg::*;
();

  localparam int COUNT_W = 16;

  // Classifier phases, tracked by the scoreboard's own copy of the machine.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HELD      = 3'd1,
    PH_LONG_WAIT = 3'd2,
    PH_GAP       = 3'd3,
    PH_SECOND    = 3'd4
  } press_phase_t;

  // One expected report.
  typedef struct packed {
    bpc_event_t ev;
    logic       idle;
  } press_report_t;

  // Tracks the classifier state and the reports still owed by the block.
  class press_scoreboard;
    logic [CFG_W-1:0]   long_ticks;
    logic [CFG_W-1:0]   window_ticks;
    press_phase_t       phase;
    logic [COUNT_W-1:0] hold_cnt;
    logic [COUNT_W-1:0] gap_cnt;
    press_report_t      pending[$];
    int                 errors;

    function new();
      long_ticks   = LONG_PRESS_RESET;
      window_ticks = DOUBLE_WINDOW_RESET;
      phase        = PH_IDLE;
      hold_cnt     = '0;
      gap_cnt      = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_W-1:0] value);
      if (idx == REG_LONG_PRESS) begin
        long_ticks = value;
      end else begin
        window_ticks = value;
      end
    endfunction

    // Counters stop at their largest value instead of wrapping.
    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Steps the machine by one accepted scan tick and queues its report.
    function void note_tick(bit released);
      press_report_t r;
      r.ev = EV_NONE;
      case (phase)
        PH_IDLE: begin
          if (!released) begin
            phase    = PH_HELD;
            hold_cnt = '0;
          end
        end
        PH_HELD: begin
          if (released) begin
            phase   = PH_GAP;
            gap_cnt = '0;
          end else begin
            hold_cnt = bump(hold_cnt);
            if (hold_cnt > long_ticks) begin
              r.ev  = EV_LONG;
              phase = PH_LONG_WAIT;
            end
          end
        end
        PH_LONG_WAIT: begin
          if (released) phase = PH_IDLE;
        end
        PH_GAP: begin
          gap_cnt = bump(gap_cnt);
          // A press at or after the window is swallowed.
          if (!released) begin
            if (gap_cnt < window_ticks) begin
              phase    = PH_SECOND;
              hold_cnt = '0;
            end
          end else if (gap_cnt > window_ticks) begin
            r.ev  = EV_SHORT;
            phase = PH_IDLE;
          end
        end
        PH_SECOND: begin
          if (released) begin
            r.ev  = EV_DOUBLE;
            phase = PH_IDLE;
          end else begin
            hold_cnt = bump(hold_cnt);
            // A long hold during a double click goes straight back to idle.
            if (hold_cnt > long_ticks) begin
              r.ev  = EV_LONG;
              phase = PH_IDLE;
            end
          end
        end
        default: phase = PH_IDLE;
      endcase
      r.idle = (phase == PH_IDLE);
      pending.push_back(r);
    endfunction

    // Compares one accepted report with the oldest expectation.
    function void check_report(logic [1:0] ev, logic idl);
      press_report_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, got event %0d idle %0d",
                 $time, ev, idl);
        return;
      end
      want = pending.pop_front();
      if (ev !== want.ev) begin
        errors++;
        $display("%0t: press_event expected %0d, got %0d", $time, want.ev, ev);
      end
      if (idl !== want.idle) begin
        errors++;
        $display("%0t: idle expected %0d, got %0d", $time, want.idle, idl);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bpc_scan_if   scan_ch ();
  bpc_report_if report_ch ();

  press_scoreboard sb = new();

  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned ticks_sent = 0;

  button_press_classifier_unit dut (
    .clk     (clk),
    .rst     (rst),
    .scan    (scan_ch),
    .report  (report_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Report sink: random stall bursts while stall_pct is nonzero.
  always begin
    @(negedge clk);
    if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      report_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    report_ch.ready <= 1'b1;
  end

  // Check every report transaction.
  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready) begin
      sb.check_report(report_ch.press_event, report_ch.idle);
    end
  end

  // Sends one scan tick; entered and left at a falling edge.
  task automatic send_tick(input bit released);
    scan_ch.valid        <= 1'b1;
    scan_ch.key_released <= released;
    do @(posedge clk); while (!scan_ch.ready);
    sb.note_tick(released);
    ticks_sent++;
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      scan_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  task automatic hold_then_release(input int unsigned hold, input int unsigned gap);
    repeat (hold) send_tick(1'b0);
    repeat (gap) send_tick(1'b1);
  endtask

  // Stops the scan stream until every expected report has come back.
  task automatic drain();
    scan_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One register transaction: setup cycle, access cycle, then idle with psel low.
  task automatic reg_access(input logic idx, input bit wr, input logic [CFG_W-1:0] value,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(DATA_W-CFG_W){1'b0}}, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Reads a register back and compares it with the scoreboard's copy.
  task automatic check_reg(input logic idx);
    logic [DATA_W-1:0] rd;
    logic [CFG_W-1:0]  want;
    want = (idx == REG_LONG_PRESS) ? sb.long_ticks : sb.window_ticks;
    reg_access(idx, 1'b0, '0, rd);
    if (rd !== {{(DATA_W-CFG_W){1'b0}}, want}) begin
      sb.errors++;
      $display("%0t: register %0d expected %0d, got %0d", $time, idx, want, rd);
    end
  endtask

  // Writes both registers with the block drained, then reads them back.
  task automatic apply_config(input logic [CFG_W-1:0] long_val,
                              input logic [CFG_W-1:0] window_val);
    logic [DATA_W-1:0] rd;
    drain();
    reg_access(REG_LONG_PRESS, 1'b1, long_val, rd);
    sb.set_reg(REG_LONG_PRESS, long_val);
    reg_access(REG_DOUBLE_WINDOW, 1'b1, window_val, rd);
    sb.set_reg(REG_DOUBLE_WINDOW, window_val);
    check_reg(REG_LONG_PRESS);
    check_reg(REG_DOUBLE_WINDOW);
  endtask

  // One random gesture, sized around the current thresholds.
  task automatic random_gesture();
    int unsigned lp;
    int unsigned wn;
    int unsigned long_hold;
    lp        = (sb.long_ticks > 36) ? 40 : sb.long_ticks + 4;
    wn        = (sb.window_ticks > 36) ? 40 : sb.window_ticks + 4;
    long_hold = (sb.long_ticks > 40) ? 45 : sb.long_ticks + 2 + $urandom_range(0, 2);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: hold_then_release($urandom_range(1, lp), $urandom_range(1, wn));
      4, 5, 6: begin
        hold_then_release($urandom_range(1, lp), $urandom_range(1, wn - 3));
        hold_then_release($urandom_range(1, lp), $urandom_range(1, wn));
      end
      7: hold_then_release(long_hold, $urandom_range(1, 4));
      8: begin
        hold_then_release($urandom_range(1, 3), $urandom_range(1, wn - 3));
        hold_then_release(long_hold, $urandom_range(1, 4));
      end
      default: begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // Main stimulus sequence.
  initial begin
    int unsigned seg_start;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    scan_ch.valid        = 1'b0;
    scan_ch.key_released = 1'b1;
    report_ch.ready      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values, then a little traffic under them.
    check_reg(REG_LONG_PRESS);
    check_reg(REG_DOUBLE_WINDOW);
    idle_pct  = 10;
    stall_pct = 10;
    seg_start = ticks_sent;
    while (ticks_sent - seg_start < 60) random_gesture();

    // Directed gestures with small thresholds.
    apply_config(16'd3, 16'd2);
    hold_then_release(2, 4);    // short press; gap passes the window value
    hold_then_release(1, 1);    // double click
    hold_then_release(1, 1);
    hold_then_release(5, 1);    // long press, then release
    hold_then_release(1, 2);    // late second press is swallowed
    hold_then_release(1, 2);
    hold_then_release(1, 1);    // long hold inside a double click
    hold_then_release(5, 1);

    // Both thresholds at zero.
    apply_config(16'd0, 16'd0);
    seg_start = ticks_sent;
    while (ticks_sent - seg_start < 80) random_gesture();

    // Both thresholds at the maximum: neither a long press nor a short press.
    apply_config(16'hFFFF, 16'hFFFF);
    idle_pct  = 1;
    stall_pct = 1;
    hold_then_release(40, 40);
    // A smaller window lets the waiting gap report its short press.
    apply_config(16'hFFFF, 16'd10);
    hold_then_release(0, 2);

    // Random segments over a range of settings.
    for (int s = 0; s < 8; s++) begin
      case (s)
        2:       apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        4:       apply_config(16'd0, 16'hFFFF);
        5:       apply_config(16'hFFFF, 16'd0);
        default: apply_config(16'($urandom_range(0, 20)), 16'($urandom_range(0, 12)));
      endcase
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 25;
      endcase
      stall_pct = $urandom_range(0, 2) * 12;
      // The closing stretch runs without idling on either side.
      if (s == 7) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      seg_start = ticks_sent;
      while (ticks_sent - seg_start < 100) random_gesture();
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
